// ===== sv/swept_box_ray_slab_test_unit_assert.svh =====
// ----------------------------------------------------------------------------
// swept box ray slab test unit - assertion macros
// clk and arst_n are taken from the scope that uses the macros
// ----------------------------------------------------------------------------
`ifndef SWEPT_BOX_RAY_SLAB_TEST_UNIT_ASSERT_SVH
`define SWEPT_BOX_RAY_SLAB_TEST_UNIT_ASSERT_SVH

// same-cycle implication
`define SBRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrs_pkg
// types, widths and helper functions of the swept box ray slab test unit
// ----------------------------------------------------------------------------
package sbrs_pkg;

	localparam int OffW  = 34;  // edge offsets and doubled start points
	localparam int DirW  = 32;
	localparam int DenW  = 32;  // direction magnitude
	localparam int HalfW = 17;  // low part of a split multiply
	localparam int ProdW = 66;
	localparam int QuoW  = 33;  // quotient bits per divide
	localparam int DvdW  = 64;
	localparam int FracW = 16;
	localparam int OutW  = 32;
	localparam int CtW   = 36;  // contact sum before halving

	typedef logic signed [OffW-1:0]  off_t;
	typedef logic signed [1:0]       tri_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [QuoW+1:0]  qs_t;

	localparam tri_t TriPos  = 2'sb01;
	localparam tri_t TriNeg  = 2'sb11;
	localparam tri_t TriZero = 2'sb00;

	localparam logic signed [OutW-1:0] SatMax = 32'sh7FFF_FFFF;
	localparam logic signed [OutW-1:0] SatMin = 32'sh8000_0000;

	// slab time: infinite marker or finite numerator over the axis direction magnitude
	typedef struct packed {
		tri_t inf;
		off_t n;
	} stime_t;

	typedef struct packed {
		logic   nan;
		stime_t nt;
		stime_t ft;
	} axis_t;

	typedef struct packed {
		logic            reject;
		stime_t          nx;
		stime_t          fx;
		stime_t          ny;
		stime_t          fy;
		logic [DenW-1:0] dxm;
		logic [DenW-1:0] dym;
		logic            dx_neg;
		logic            dy_neg;
		off_t            s2x;
		off_t            s2y;
	} slab_t;

	typedef struct packed {
		logic hit;
		logic tvalid;
		tri_t near_inf;
		logic near_neg;
		logic t_ovf;
		logic sel_x;
		tri_t nrm_x;
		tri_t nrm_y;
		logic oth_neg;
		qs_t  exact_q;
		off_t s2x;
		off_t s2y;
	} side_t;

	typedef struct packed {
		logic [DvdW-1:0] dvd_a;
		logic [DvdW-1:0] dvd_b;
		logic [DenW-1:0] dsr;
		side_t           side;
	} div_in_t;

	typedef struct packed {
		logic [QuoW-1:0] q_a;
		logic [QuoW-1:0] q_b;
		logic            rnz_a;
		logic            rnz_b;
		side_t           side;
	} div_out_t;

	function automatic tri_t sgn3(input off_t v);
		return (v == 0) ? TriZero : ((v < 0) ? TriNeg : TriPos);
	endfunction

	// near and far times of one axis, ordered
	function automatic axis_t slab_axis(input off_t nd, input off_t fd,
			input logic signed [DirW-1:0] dc);
		axis_t  r;
		stime_t a;
		stime_t b;
		logic   swap;
		if (dc == 0) begin
			a.inf = sgn3(nd);
			a.n   = '0;
			b.inf = sgn3(fd);
			b.n   = '0;
			r.nan = (nd == 0) || (fd == 0);
			swap  = a.inf > b.inf;
		end else begin
			a.inf = TriZero;
			b.inf = TriZero;
			a.n   = (dc < 0) ? -nd : nd;
			b.n   = (dc < 0) ? -fd : fd;
			r.nan = 1'b0;
			swap  = a.n > b.n;
		end
		r.nt = swap ? b : a;
		r.ft = swap ? a : b;
		return r;
	endfunction

	// order of two times given their cross-scaled numerators
	function automatic tri_t tcmp3(input tri_t ai, input tri_t bi,
			input prod_t pa, input prod_t pb);
		if (ai != TriZero || bi != TriZero)
			return (ai < bi) ? TriNeg : ((ai == bi) ? TriZero : TriPos);
		return (pa < pb) ? TriNeg : ((pa == pb) ? TriZero : TriPos);
	endfunction

	function automatic logic signed [OutW-1:0] sat32(input logic signed [CtW-1:0] v);
		if (v > CtW'(SatMax))
			return SatMax;
		if (v < CtW'(SatMin))
			return SatMin;
		return OutW'(v);
	endfunction

endpackage

// ===== sv/swept_box_ray_slab_test_unit.sv =====
// ----------------------------------------------------------------------------
// swept_box_ray_slab_test_unit
// 2d slab test of a ray or swept box against a box, exact Q16.16
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  cmd, origin_x/y, mover_w/h, dir_x/y, box_x/y, box_w/h
//  out      out_valid/out_ready  hit, contact_x/y, normal_x/y, hit_time, time_valid
//
// one item enters per cycle while no stall holds the pipeline; 2 slab stages, 3 ordering stages,
// 33 divider stages (one quotient bit each) and the output register
// arst_n clears all valid bits, payload registers are not reset
// a stall holds every stage that has no hole after it; holes close up under a stall
// ----------------------------------------------------------------------------
module swept_box_ray_slab_test_unit import sbrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic        [30:0] mover_w,
	input  logic        [30:0] mover_h,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] box_x,
	input  logic signed [31:0] box_y,
	input  logic        [30:0] box_w,
	input  logic        [30:0] box_h,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] contact_x,
	output logic signed [31:0] contact_y,
	output logic signed [1:0]  normal_x,
	output logic signed [1:0]  normal_y,
	output logic signed [31:0] hit_time,
	output logic               time_valid
);

	localparam logic [QuoW:0] MinMag = (QuoW+1)'(64'd1 << (OutW - 1));

	logic     sl_valid, sl_ready, or_valid, or_ready, dv_valid, dv_ready;
	slab_t    sl_data;
	div_in_t  or_data;
	div_out_t dv;

	logic en_o;
	logic valid_q, hit_q, tvalid_q;
	logic signed [OutW-1:0] cx_q, cy_q, ht_q;
	tri_t nx_q, ny_q;

	logic [QuoW:0] mag_a, mag_b;
	qs_t qs_div, qs_x, qs_y;
	logic signed [CtW-1:0] c2x, c2y;
	logic signed [OutW-1:0] ht;

	sbrs_slab u_slab (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.mover_w   (mover_w),
		.mover_h   (mover_h),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.box_x     (box_x),
		.box_y     (box_y),
		.box_w     (box_w),
		.box_h     (box_h),
		.out_valid (sl_valid),
		.out_ready (sl_ready),
		.out_data  (sl_data)
	);

	sbrs_order u_order (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sl_valid),
		.in_ready  (sl_ready),
		.in_data   (sl_data),
		.out_valid (or_valid),
		.out_ready (or_ready),
		.out_data  (or_data)
	);

	sbrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (or_valid),
		.in_ready  (or_ready),
		.in_data   (or_data),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_data  (dv)
	);

	assign en_o     = !valid_q || out_ready;
	assign dv_ready = en_o;

	always_comb begin
		// entry time, rounded toward minus infinity
		mag_a = {1'b0, dv.q_a} + (QuoW+1)'(dv.rnz_a);
		if (!dv.side.tvalid)
			ht = '0;
		else if (dv.side.near_inf == TriPos)
			ht = SatMax;
		else if (dv.side.near_inf == TriNeg)
			ht = SatMin;
		else if (!dv.side.near_neg)
			ht = (dv.side.t_ovf || dv.q_a[QuoW-1:OutW-1] != '0) ? SatMax : OutW'(dv.q_a);
		else
			ht = (dv.side.t_ovf || mag_a > MinMag) ? SatMin : OutW'(-mag_a);

		// other-axis step: ceiling when its direction is negative
		mag_b  = {1'b0, dv.q_b} + (QuoW+1)'(dv.side.oth_neg & dv.rnz_b);
		qs_div = dv.side.oth_neg ? -qs_t'(mag_b) : qs_t'(mag_b);
		qs_x   = dv.side.sel_x ? dv.side.exact_q : qs_div;
		qs_y   = dv.side.sel_x ? qs_div : dv.side.exact_q;
		c2x    = CtW'(dv.side.s2x) + CtW'(qs_x);
		c2y    = CtW'(dv.side.s2y) + CtW'(qs_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en_o)
			valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en_o && dv_valid) begin
			hit_q    <= dv.side.hit;
			tvalid_q <= dv.side.tvalid;
			ht_q     <= ht;
			cx_q     <= dv.side.hit ? sat32(c2x >>> 1) : '0;
			cy_q     <= dv.side.hit ? sat32(c2y >>> 1) : '0;
			nx_q     <= dv.side.hit ? dv.side.nrm_x : TriZero;
			ny_q     <= dv.side.hit ? dv.side.nrm_y : TriZero;
		end
	end

	assign out_valid  = valid_q;
	assign hit        = hit_q;
	assign contact_x  = cx_q;
	assign contact_y  = cy_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign hit_time   = ht_q;
	assign time_valid = tvalid_q;

endmodule

// ===== sv/sbrs_slab.sv =====
// ----------------------------------------------------------------------------
// sbrs_slab
// edge offsets of both axes, then ordered near and far slab times
// ----------------------------------------------------------------------------
module sbrs_slab import sbrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic signed [31:0]     origin_x,
	input  logic signed [31:0]     origin_y,
	input  logic        [30:0]     mover_w,
	input  logic        [30:0]     mover_h,
	input  logic signed [31:0]     dir_x,
	input  logic signed [31:0]     dir_y,
	input  logic signed [31:0]     box_x,
	input  logic signed [31:0]     box_y,
	input  logic        [30:0]     box_w,
	input  logic        [30:0]     box_h,
	output logic                   out_valid,
	input  logic                   out_ready,
	output slab_t                  out_data
);

	logic en1, en2;
	logic v_s1, v_s2;
	off_t ndx_s1, fdx_s1, ndy_s1, fdy_s1, s2x_s1, s2y_s1;
	logic signed [DirW-1:0] dx_s1, dy_s1;
	slab_t sl_s2;

	off_t ox, oy, bx, by, mw, mh, bw, bh;
	axis_t ax, ay;
	slab_t sl;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign ox = off_t'(origin_x);
	assign oy = off_t'(origin_y);
	assign bx = off_t'(box_x);
	assign by = off_t'(box_y);
	assign bw = off_t'(box_w);
	assign bh = off_t'(box_h);
	assign mw = cmd ? off_t'(mover_w) : '0;
	assign mh = cmd ? off_t'(mover_h) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ndx_s1 <= bx - ox - mw;
			fdx_s1 <= bx + bw - ox;
			ndy_s1 <= by + mh - oy;
			fdy_s1 <= by - bh - oy;
			// start point kept doubled so the mover centre stays exact
			s2x_s1 <= (ox <<< 1) + mw;
			s2y_s1 <= (oy <<< 1) - mh;
			dx_s1  <= dir_x;
			dy_s1  <= dir_y;
		end
	end

	always_comb begin
		ax        = slab_axis(ndx_s1, fdx_s1, dx_s1);
		ay        = slab_axis(ndy_s1, fdy_s1, dy_s1);
		sl.reject = (dx_s1 == 0 && dy_s1 == 0) || ax.nan || ay.nan;
		sl.nx     = ax.nt;
		sl.fx     = ax.ft;
		sl.ny     = ay.nt;
		sl.fy     = ay.ft;
		sl.dxm    = dx_s1[DirW-1] ? DenW'(-dx_s1) : DenW'(dx_s1);
		sl.dym    = dy_s1[DirW-1] ? DenW'(-dy_s1) : DenW'(dy_s1);
		sl.dx_neg = dx_s1[DirW-1];
		sl.dy_neg = dy_s1[DirW-1];
		sl.s2x    = s2x_s1;
		sl.s2y    = s2y_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1)
			sl_s2 <= sl;
	end

	assign out_valid = v_s2;
	assign out_data  = sl_s2;

endmodule

// ===== sv/sbrs_order.sv =====
// ----------------------------------------------------------------------------
// sbrs_order
// cross-scales the slab times, orders them and picks near time and normal
// ----------------------------------------------------------------------------
module sbrs_order import sbrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  slab_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output div_in_t out_data
);

	localparam int PhW = OffW - HalfW + DenW + 1;
	localparam int PlW = HalfW + DenW;

	logic en3, en4, en5;
	logic v_s3, v_s4, v_s5;
	slab_t sl_s3, sl_s4;
	logic signed [PhW-1:0] ph_s3 [4];
	logic        [PlW-1:0] pl_s3 [4];
	prod_t p_s4 [4];
	div_in_t dq_s5;

	off_t            nsel [4];
	logic [DenW-1:0] dsel [4];
	div_in_t         dq;

	stime_t nr, fr;
	logic [DenW-1:0] nd_m;
	tri_t c_nxfy, c_nyfx, c_nn, c_ff;
	logic early, far_lt0, near_lt0, near_gt1, tvalid;
	off_t nmag;
	prod_t poth;
	qs_t e2;
	logic own_neg;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign in_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3)
				v_s3 <= in_valid;
			if (en4)
				v_s4 <= v_s3;
			if (en5)
				v_s5 <= v_s4;
		end
	end

	// x times scale by |dy|, y times by |dx|
	always_comb begin
		nsel[0] = in_data.nx.n;
		nsel[1] = in_data.fx.n;
		nsel[2] = in_data.ny.n;
		nsel[3] = in_data.fy.n;
		dsel[0] = in_data.dym;
		dsel[1] = in_data.dym;
		dsel[2] = in_data.dxm;
		dsel[3] = in_data.dxm;
	end

	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			sl_s3 <= in_data;
			for (int i = 0; i < 4; i++) begin
				ph_s3[i] <= $signed(nsel[i][OffW-1:HalfW]) * $signed({1'b0, dsel[i]});
				pl_s3[i] <= nsel[i][HalfW-1:0] * dsel[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			sl_s4 <= sl_s3;
			for (int i = 0; i < 4; i++)
				p_s4[i] <= (prod_t'(ph_s3[i]) <<< HalfW) + prod_t'(pl_s3[i]);
		end
	end

	always_comb begin
		c_nxfy = tcmp3(sl_s4.nx.inf, sl_s4.fy.inf, p_s4[0], p_s4[3]);
		c_nyfx = tcmp3(sl_s4.ny.inf, sl_s4.fx.inf, p_s4[2], p_s4[1]);
		c_nn   = tcmp3(sl_s4.nx.inf, sl_s4.ny.inf, p_s4[0], p_s4[2]);
		c_ff   = tcmp3(sl_s4.fx.inf, sl_s4.fy.inf, p_s4[1], p_s4[3]);
		early  = (c_nxfy == TriPos) || (c_nyfx == TriPos);

		dq.side.sel_x = (c_nn != TriNeg);
		nr   = dq.side.sel_x ? sl_s4.nx : sl_s4.ny;
		nd_m = dq.side.sel_x ? sl_s4.dxm : sl_s4.dym;
		fr   = (c_ff != TriPos) ? sl_s4.fx : sl_s4.fy;

		far_lt0  = (fr.inf == TriNeg) || (fr.inf == TriZero && fr.n < 0);
		near_lt0 = (nr.inf == TriNeg) || (nr.inf == TriZero && nr.n < 0);
		near_gt1 = (nr.inf == TriPos) || (nr.inf == TriZero && nr.n > off_t'(nd_m));
		tvalid   = !sl_s4.reject && !early;

		dq.side.tvalid   = tvalid;
		dq.side.hit      = tvalid && !far_lt0 && !near_lt0 && !near_gt1;
		dq.side.near_inf = nr.inf;
		dq.side.near_neg = nr.n < 0;

		// entry time lane: |n| * 2^16 / d, overflow flagged up front
		nmag           = (nr.n < 0) ? -nr.n : nr.n;
		dq.dvd_a       = DvdW'(nmag[OffW-2:0]) << FracW;
		dq.side.t_ovf  = DvdW'(nmag[OffW-2:0]) >= (DvdW'(nd_m) << (QuoW - FracW));
		dq.dsr         = nd_m;

		// contact along the other axis needs a divide; along the near axis it is exact
		poth            = dq.side.sel_x ? p_s4[0] : p_s4[2];
		dq.dvd_b        = {poth[DvdW-2:0], 1'b0};
		dq.side.oth_neg = dq.side.sel_x ? sl_s4.dy_neg : sl_s4.dx_neg;
		own_neg         = dq.side.sel_x ? sl_s4.dx_neg : sl_s4.dy_neg;
		e2              = qs_t'(nr.n) <<< 1;
		dq.side.exact_q = own_neg ? -e2 : e2;

		dq.side.nrm_x = (c_nn == TriPos) ? (sl_s4.dx_neg ? TriPos : TriNeg) : TriZero;
		dq.side.nrm_y = (c_nn == TriNeg) ? (sl_s4.dy_neg ? TriPos : TriNeg) : TriZero;
		dq.side.s2x   = sl_s4.s2x;
		dq.side.s2y   = sl_s4.s2y;
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4)
			dq_s5 <= dq;
	end

	assign out_valid = v_s5;
	assign out_data  = dq_s5;

endmodule

// ===== sv/sbrs_div.sv =====
// ----------------------------------------------------------------------------
// sbrs_div
// two-lane pipelined restoring divider, one quotient bit per stage,
// both lanes share the divisor
// ----------------------------------------------------------------------------
module sbrs_div import sbrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  div_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output div_out_t out_data
);

	localparam int WW = DenW + QuoW;

	// partial remainder on top, dividend bits shifting out, quotient bits shifting in
	typedef struct packed {
		logic [WW-1:0]   wa;
		logic [WW-1:0]   wb;
		logic [DenW-1:0] dsr;
		side_t           side;
	} dstage_t;

	function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
			input logic [DenW-1:0] dsr);
		logic [DenW:0] sh;
		logic [DenW:0] diff;
		logic          ge;
		sh   = w[WW-1:QuoW-1];
		ge   = sh >= {1'b0, dsr};
		diff = sh - {1'b0, dsr};
		return {ge ? diff[DenW-1:0] : sh[DenW-1:0], w[QuoW-2:0], ge};
	endfunction

	dstage_t         st_sk [QuoW];
	logic [QuoW-1:0] v_sk;
	logic [QuoW-1:0] en;

	assign in_ready = en[0];

	for (genvar k = 0; k < QuoW; k++) begin : g_stage
		dstage_t prv;
		logic    vin;

		if (k == 0) begin : g_first
			assign vin      = in_valid;
			assign prv.wa   = WW'(in_data.dvd_a);
			assign prv.wb   = WW'(in_data.dvd_b);
			assign prv.dsr  = in_data.dsr;
			assign prv.side = in_data.side;
		end else begin : g_next
			assign vin = v_sk[k-1];
			assign prv = st_sk[k-1];
		end

		// a stage moves when the output is taken, when it is empty or when some later stage has a hole
		assign en[k] = out_ready || !(&v_sk[QuoW-1:k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sk[k] <= 1'b0;
			else if (en[k])
				v_sk[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en[k] && vin) begin
				st_sk[k].wa   <= div_step(prv.wa, prv.dsr);
				st_sk[k].wb   <= div_step(prv.wb, prv.dsr);
				st_sk[k].dsr  <= prv.dsr;
				st_sk[k].side <= prv.side;
			end
		end
	end

	assign out_valid      = v_sk[QuoW-1];
	assign out_data.q_a   = st_sk[QuoW-1].wa[QuoW-1:0];
	assign out_data.q_b   = st_sk[QuoW-1].wb[QuoW-1:0];
	assign out_data.rnz_a = |st_sk[QuoW-1].wa[WW-1:QuoW];
	assign out_data.rnz_b = |st_sk[QuoW-1].wb[WW-1:QuoW];
	assign out_data.side  = st_sk[QuoW-1].side;

endmodule

// ===== sv/sbrs_checker.sv =====
// ----------------------------------------------------------------------------
// sbrs_checker
// port-level checks of the swept box ray slab test unit, bound to the top level
// ----------------------------------------------------------------------------
`include "swept_box_ray_slab_test_unit_assert.svh"

module sbrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               hit,
	input logic signed [31:0] contact_x,
	input logic signed [31:0] contact_y,
	input logic signed [1:0]  normal_x,
	input logic signed [1:0]  normal_y,
	input logic signed [31:0] hit_time,
	input logic               time_valid
);

	logic [101:0] beat;
	logic         hit_ok;
	logic         rej_zero;
	logic         miss_zero;

	assign beat      = {hit, contact_x, contact_y, normal_x, normal_y, hit_time, time_valid};
	assign hit_ok    = time_valid && !hit_time[31] && hit_time <= 32'sd65536
		&& !(normal_x != 2'sb00 && normal_y != 2'sb00);
	assign rej_zero  = !hit && hit_time == 32'sd0 && contact_x == 32'sd0
		&& contact_y == 32'sd0;
	assign miss_zero = contact_x == 32'sd0 && contact_y == 32'sd0
		&& normal_x == 2'sb00 && normal_y == 2'sb00;

	// a stalled result beat holds
	`SBRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(beat), "stalled result changed")

	// a hit has an entry time in [0,1] and at most one normal axis
	`SBRS_ASSERT_IMP(a_hit_time, out_valid && hit, hit_ok, "hit with bad time or normal")

	// early reject clears the hit flag, the entry time and the contact
	`SBRS_ASSERT_IMP(a_reject_zero, out_valid && !time_valid, rej_zero, "rejected beat not zero")

	// a miss has no contact or normal
	`SBRS_ASSERT_IMP(a_miss_zero, out_valid && !hit, miss_zero, "miss with contact")

endmodule

bind swept_box_ray_slab_test_unit sbrs_checker u_sbrs_checker (.*);
